@@ sv/skp_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skp_pkg
// Shared types and constants for the sysex keypress parser: packet kinds,
// end status codes, the vendor prefix and the transaction payload structs.
// ----------------------------------------------------------------------------
package skp_pkg;

   // default number of bytes kept per message
   localparam int STORE_DEPTH_DEFAULT = 32;

   // message layout
   localparam int PREFIX_LEN  = 8;
   localparam int KEY_MSG_LEN = 12;
   localparam int CMD_POS     = 8;
   localparam int BUTTON_POS  = 9;
   localparam int VALUE_POS   = 10;

   localparam logic [7:0] CMD_KEYPRESS = 8'h00;

   localparam logic [7:0] VENDOR_PREFIX [PREFIX_LEN] = '{
      8'hF0, 8'h00, 8'h20, 8'h6B, 8'h7F, 8'h42, 8'h02, 8'h00
   };

   // usb-midi packet kinds
   typedef enum logic [2:0] {
      KIND_CONT  = 3'd0,
      KIND_END1  = 3'd1,
      KIND_END2  = 3'd2,
      KIND_END3  = 3'd3,
      KIND_OTHER = 3'd4
   } kind_type;

   // end of message status
   typedef enum logic [1:0] {
      STATUS_NONE         = 2'd0,
      STATUS_KEYPRESS     = 2'd1,
      STATUS_UNKNOWN_CMD  = 2'd2,
      STATUS_UNRECOGNIZED = 2'd3
   } status_type;

   typedef struct packed {
      logic [2:0] kind;
      logic [7:0] first_byte;
      logic [7:0] second_byte;
      logic [7:0] third_byte;
   } req_payload_type;

   typedef struct packed {
      logic       handled;
      logic [1:0] end_status;
      logic [7:0] button_id;
      logic       key_down;
   } rsp_payload_type;

endpackage

@@ sv/skp_req_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skp_req_if
// Valid/ready channel carrying one usb-midi packet per transaction.
// ----------------------------------------------------------------------------
interface skp_req_if;
   logic                     valid;
   logic                     ready;
   skp_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/skp_rsp_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skp_rsp_if
// Valid/ready channel carrying one parse result per transaction.
// ----------------------------------------------------------------------------
interface skp_rsp_if;
   logic                     valid;
   logic                     ready;
   skp_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

@@ sv/skp_msg_track.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skp_msg_track
// Message state and decode: appends up to three packet bytes, keeps the
// running prefix match and byte captures, and classifies the message end.
// ----------------------------------------------------------------------------
module skp_msg_track #(
   parameter int STORE_DEPTH = skp_pkg::STORE_DEPTH_DEFAULT
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step_en,
   input  skp_pkg::req_payload_type packet,
   output skp_pkg::rsp_payload_type result
);

   localparam int CountWidth = $clog2(STORE_DEPTH + 1);
   localparam int SumWidth   = CountWidth + 1;

   logic [CountWidth-1:0] count_ff, count_in;
   logic                  match_ff, match_in;
   logic [7:0]            cmd_ff, cmd_in;
   logic [7:0]            button_ff, button_in;
   logic [7:0]            value_ff, value_in;

   logic                  is_sysex;
   logic                  is_end;
   logic [1:0]            num_bytes;
   logic [7:0]            pkt_byte [3];
   logic [SumWidth-1:0]   pos [3];
   logic [2:0]            take;
   logic [1:0]            take_cnt;
   logic [CountWidth-1:0] count_next;
   logic                  match_next;

   // kind decode
   always_comb begin
      is_sysex  = 1'b1;
      is_end    = 1'b1;
      num_bytes = 2'd3;
      case (packet.kind)
         skp_pkg::KIND_CONT: begin
            is_end = 1'b0;
         end
         skp_pkg::KIND_END1: begin
            num_bytes = 2'd1;
         end
         skp_pkg::KIND_END2: begin
            num_bytes = 2'd2;
         end
         skp_pkg::KIND_END3: begin
            num_bytes = 2'd3;
         end
         default: begin
            is_sysex  = 1'b0;
            is_end    = 1'b0;
            num_bytes = 2'd0;
         end
      endcase
   end

   assign pkt_byte[0] = packet.first_byte;
   assign pkt_byte[1] = packet.second_byte;
   assign pkt_byte[2] = packet.third_byte;

   // per-byte position, drop past store end, prefix check and captures
   always_comb begin
      match_next = match_ff;
      cmd_in     = cmd_ff;
      button_in  = button_ff;
      value_in   = value_ff;
      for (int k = 0; k < 3; k++) begin
         pos[k]  = SumWidth'(count_ff) + SumWidth'(k);
         take[k] = is_sysex && (2'(k) < num_bytes) &&
                   (pos[k] < SumWidth'(STORE_DEPTH));
         if (take[k]) begin
            if (pos[k] < SumWidth'(skp_pkg::PREFIX_LEN)) begin
               if (pkt_byte[k] != skp_pkg::VENDOR_PREFIX[pos[k][2:0]]) begin
                  match_next = 1'b0;
               end
            end else if (pos[k] == SumWidth'(skp_pkg::CMD_POS)) begin
               cmd_in = pkt_byte[k];
            end else if (pos[k] == SumWidth'(skp_pkg::BUTTON_POS)) begin
               button_in = pkt_byte[k];
            end else if (pos[k] == SumWidth'(skp_pkg::VALUE_POS)) begin
               value_in = pkt_byte[k];
            end
         end
      end
      take_cnt   = 2'(take[0]) + 2'(take[1]) + 2'(take[2]);
      count_next = count_ff + CountWidth'(take_cnt);
   end

   // end of message classification
   always_comb begin
      result.handled    = is_sysex;
      result.end_status = skp_pkg::STATUS_NONE;
      result.button_id  = 8'h00;
      result.key_down   = 1'b0;
      if (is_end) begin
         if (count_next == CountWidth'(skp_pkg::KEY_MSG_LEN) && match_next) begin
            if (cmd_in == skp_pkg::CMD_KEYPRESS) begin
               result.end_status = skp_pkg::STATUS_KEYPRESS;
               result.button_id  = button_in;
               result.key_down   = (value_in != 8'h00);
            end else begin
               result.end_status = skp_pkg::STATUS_UNKNOWN_CMD;
            end
         end else begin
            result.end_status = skp_pkg::STATUS_UNRECOGNIZED;
         end
      end
   end

   // message restarts on an end or on any non-sysex packet
   always_comb begin
      if (!is_sysex || is_end) begin
         count_in = '0;
         match_in = 1'b1;
      end else begin
         count_in = count_next;
         match_in = match_next;
      end
   end

   // message state
   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         match_ff <= 1'b1;
      end else if (step_en) begin
         count_ff <= count_in;
         match_ff <= match_in;
      end
   end

   // captures, written only at their positions
   always_ff @(posedge clock) begin
      if (step_en) begin
         cmd_ff    <= cmd_in;
         button_ff <= button_in;
         value_ff  <= value_in;
      end
   end

endmodule

@@ sv/sysex_keypress_parser_core.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sysex_keypress_parser_core
// Reassembles system-exclusive messages from usb-midi packets and reports a
// decoded keypress, unknown command or unrecognized message at each end.
//
//   channel   direction  contents
//   req_chan  in         kind, first_byte, second_byte, third_byte
//   rsp_chan  out        handled, end_status, button_id, key_down
//
// One transaction per cycle sustained while the result is not stalled; each
// packet passes through the input register, then the result register.
// Each packet's bytes are checked and counted in one pass, so the message
// state is ready for the next packet in the following cycle.
// Synchronous reset clears the message state and the valid flags of both register stages.
// A stalled result holds the pipeline; the input register still takes one
// transaction while the result register is full.
// ----------------------------------------------------------------------------
module sysex_keypress_parser_core #(
   parameter int STORE_DEPTH = skp_pkg::STORE_DEPTH_DEFAULT
) (
   input logic        clock,
   input logic        reset,
   skp_req_if.sink    req_chan,
   skp_rsp_if.source  rsp_chan
);

   logic                     req_valid_ff, req_valid_in;
   skp_pkg::req_payload_type req_data_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   skp_pkg::rsp_payload_type rsp_data_ff;
   skp_pkg::rsp_payload_type step_result;
   logic                     advance;
   logic                     step_en;
   logic                     req_take;

   // pipeline control
   assign advance          = !rsp_valid_ff || rsp_chan.ready;
   assign step_en          = req_valid_ff && advance;
   assign req_chan.ready   = !req_valid_ff || advance;
   assign req_take         = req_chan.valid && req_chan.ready;

   assign req_valid_in = req_take ? 1'b1 : (step_en ? 1'b0 : req_valid_ff);
   assign rsp_valid_in = step_en ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);

   // message tracking and decode
   skp_msg_track #(
      .STORE_DEPTH (STORE_DEPTH)
   ) u_msg_track (
      .clock   (clock),
      .reset   (reset),
      .step_en (step_en),
      .packet  (req_data_ff),
      .result  (step_result)
   );

   // valid flags
   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_take) begin
         req_data_ff <= req_chan.payload;
      end
      if (step_en) begin
         rsp_data_ff <= step_result;
      end
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.payload = rsp_data_ff;

endmodule
